>>> rtl/core/led_breathing_sine_generator_top_defines.svh
// Assertion macros shared by the LED breathing sine generator RTL.
// Include with the bare file name; expects clk and rst in scope.
`ifndef LED_BREATHING_SINE_GENERATOR_TOP_DEFINES_SVH
`define LED_BREATHING_SINE_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LBSG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LBSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lbsg_pkg.sv
// Package for the LED breathing sine generator: widths, codes and FSM type.
// No dependencies.
package lbsg_pkg;

  localparam int PHASE_BITS_DEF = 16;
  localparam int STEP_W = 16;
  localparam int LED_W = 8;
  localparam int SINE_W = 16;
  localparam int KIND_W = 2;
  localparam int FRAC_SH = 15;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OPS,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 2'd0,
    KIND_PEAK   = 2'd1,
    KIND_TROUGH = 2'd2,
    KIND_BRIGHT = 2'd3
  } kind_t;

  // Operand width of the shared multiplier: holds both the phase terms and Q1.15.
  function automatic int mul_width(input int pb);
    return (pb + 1 > SINE_W + 1) ? pb + 1 : SINE_W + 1;
  endfunction

endpackage

>>> rtl/core/lbsg_mul.sv
// Shared signed multiplier with a registered product.
// Standalone; width handed down from the top level.
module lbsg_mul #(
  parameter int W = 17
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

>>> rtl/core/led_breathing_sine_generator_top.sv
// LED breathing sine generator: the result register is loaded after the input transfer
// through the operand select, multiply and finish states, all on one shared multiplier.
// A new item is accepted only after the result of the previous one has been loaded.
// A waiting result holds the finish step until it is taken.
// Synchronous reset clears phase, sine value, phase step and output valid.
// Depends on lbsg_pkg, lbsg_mul and led_breathing_sine_generator_top_defines.svh.
`include "led_breathing_sine_generator_top_defines.svh"

module led_breathing_sine_generator_top #(
  parameter int PHASE_BITS = lbsg_pkg::PHASE_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_we,
  input  logic [lbsg_pkg::STEP_W-1:0]               cfg_wdata,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  // led_min [7:0], led_max [15:8]
  input  logic [2*lbsg_pkg::LED_W-1:0]              s_tdata,
  // kind [1:0]
  input  logic [lbsg_pkg::KIND_W-1:0]               s_tuser,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // brightness [7:0], sine_value [23:8]
  output logic [lbsg_pkg::LED_W+lbsg_pkg::SINE_W-1:0] m_tdata
);
  import lbsg_pkg::*;

  localparam int F = PHASE_BITS - 1;
  localparam int MW = mul_width(PHASE_BITS);
  localparam int PW = 2 * MW;
  localparam int SH_R = (2 * F >= 17) ? 2 * F - 17 : 0;
  localparam int SH_L = (2 * F >= 17) ? 0 : 17 - 2 * F;
  localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);
  localparam logic [F:0] HALF = (F + 1)'(1) << F;
  localparam logic [SINE_W:0] POS_MAX = 17'h07FFF;
  localparam logic [SINE_W:0] NEG_MAX = 17'h08000;

  state_t state, state_next;
  kind_t kind;
  logic [STEP_W-1:0] step;
  logic [PHASE_BITS+STEP_W-1:0] step_wide;
  logic [PHASE_BITS-1:0] step_ph, phase, neg_ph, mag;
  logic [F:0] comp;
  logic [SINE_W-1:0] sine_now;
  logic [LED_W-1:0] led_min, led_max, off, off_next;
  logic [LED_W:0] sum_lm;
  logic signed [LED_W+1:0] amp;
  logic signed [MW-1:0] op_a, op_b, op_a_next, op_b_next;
  logic signed [PW-1:0] prod;
  logic mul_en, fin_go;
  logic [PW-1:0] mshift;
  logic [SINE_W:0] mclamp, mneg;
  logic [SINE_W-1:0] tick_sine;
  logic signed [PW:0] t;
  logic [PW-15:0] hi;
  logic [LED_W-1:0] bright_calc, bright_out;
  logic [SINE_W-1:0] sine_out;

  assign step_wide = {{PHASE_BITS{1'b0}}, step};
  assign step_ph = step_wide[PHASE_BITS-1:0];

  // Operand selection for the multiplier.
  assign neg_ph = -phase;
  assign mag = phase[F] ? neg_ph : phase;
  assign comp = HALF - mag;
  assign sum_lm = {1'b0, led_max} + {1'b0, led_min};
  assign off_next = sum_lm[LED_W:1];
  assign amp = $signed({2'b00, led_max}) - $signed({2'b00, off_next});

  always_comb begin
    if (kind == KIND_BRIGHT) begin
      op_a_next = $signed({{(MW - SINE_W){sine_now[SINE_W-1]}}, sine_now});
      op_b_next = $signed({{(MW - LED_W - 2){amp[LED_W+1]}}, amp});
    end else begin
      op_a_next = $signed({{(MW - PHASE_BITS){1'b0}}, mag});
      op_b_next = $signed({{(MW - PHASE_BITS){1'b0}}, comp});
    end
  end

  lbsg_mul #(
    .W(MW)
  ) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (op_a),
    .b   (op_b),
    .prod(prod)
  );

  // Finish step for a tick: scale to Q1.15, clamp and apply the sign.
  assign mshift = ($unsigned(prod) >> SH_R) << SH_L;
  always_comb begin
    if (phase[F]) begin
      mclamp = (mshift > PW'(NEG_MAX)) ? NEG_MAX : mshift[SINE_W:0];
    end else begin
      mclamp = (mshift > PW'(POS_MAX)) ? POS_MAX : mshift[SINE_W:0];
    end
  end
  assign mneg = -mclamp;
  assign tick_sine = phase[F] ? mneg[SINE_W-1:0] : mclamp[SINE_W-1:0];

  // Finish step for brightness: add the offset, truncate and clamp.
  assign t = $signed({prod[PW-1], prod})
           + $signed({{(PW + 1 - LED_W - FRAC_SH){1'b0}}, off, {FRAC_SH{1'b0}}});
  assign hi = $unsigned(t[PW:FRAC_SH]);
  always_comb begin
    if (t[PW]) begin
      bright_calc = '0;
    end else if (hi > (PW - 14)'(255)) begin
      bright_calc = '1;
    end else begin
      bright_calc = hi[LED_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    s_tready = 1'b0;
    mul_en = 1'b0;
    fin_go = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_OPS;
        end
      end
      ST_OPS: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        mul_en = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!m_tvalid || m_tready) begin
          fin_go = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      phase <= '0;
      sine_now <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        step <= cfg_wdata;
      end
      if (s_tvalid && s_tready) begin
        case (kind_t'(s_tuser))
          KIND_TICK:   phase <= phase + step_ph;
          KIND_PEAK:   phase <= QUARTER;
          KIND_TROUGH: phase <= -QUARTER;
          default:     phase <= phase;
        endcase
      end
      if (fin_go) begin
        m_tvalid <= 1'b1;
        if (kind == KIND_TICK) begin
          sine_now <= tick_sine;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      kind <= kind_t'(s_tuser);
      led_min <= s_tdata[LED_W-1:0];
      led_max <= s_tdata[2*LED_W-1:LED_W];
    end
    if (state == ST_OPS) begin
      op_a <= op_a_next;
      op_b <= op_b_next;
      off <= off_next;
    end
    if (fin_go) begin
      bright_out <= (kind == KIND_BRIGHT) ? bright_calc : '0;
      sine_out <= (kind == KIND_TICK) ? tick_sine : sine_now;
    end
  end

  assign m_tdata = {sine_out, bright_out};

  `LBSG_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state == ST_OPS, "Start missed.")
  `LBSG_ASSERT_NEXT(a_bright_zero, fin_go && kind != KIND_BRIGHT, bright_out == '0, "Bad level.")
  `LBSG_ASSERT_NEXT(a_sine_held, fin_go && kind != KIND_TICK, sine_out == sine_now, "Sine moved.")
  `LBSG_ASSERT_NEXT(a_sine_sign, fin_go && kind == KIND_TICK && !phase[F], !sine_now[SINE_W-1], "Bad sign.")

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for led_breathing_sine_generator_top.
// It drives tick, peak, trough and brightness transfers, predicts each result in
// a local model of the phase accumulator and the sine, and checks each result.
// Depends on lbsg_pkg and the RTL of the block.
module tb_top;
  import lbsg_pkg::*;

  localparam int PB = PHASE_BITS_DEF;
  localparam int SCALE_SH = 2 * (PB - 1) - 17;
  localparam int STALL_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 170;

  typedef struct packed {
    logic [LED_W-1:0]         brightness;
    logic signed [SINE_W-1:0] sine_value;
  } led_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [STEP_W-1:0] cfg_wdata;
  logic s_tvalid;
  logic s_tready;
  logic [2*LED_W-1:0] s_tdata;
  logic [KIND_W-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [LED_W+SINE_W-1:0] m_tdata;

  logic [PB-1:0] phase_acc;
  logic signed [SINE_W-1:0] sine_acc;
  logic [STEP_W-1:0] step_reg;
  led_result_t pending_results[$];
  int mismatch_cnt;
  int stall_cnt;
  bit idle_on;

  led_breathing_sine_generator_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [SINE_W-1:0] sine_at(input logic [PB-1:0] ph);
    logic [PB-1:0] neg_ph;
    longint mag;
    longint m;
    neg_ph = -ph;
    mag = ph[PB-1] ? longint'(neg_ph) : longint'(ph);
    if (ph[PB-1] && mag == 0) begin
      mag = longint'(1) << (PB - 1);
    end
    m = mag * ((longint'(1) << (PB - 1)) - mag);
    if (SCALE_SH >= 0) begin
      m = m >> SCALE_SH;
    end else begin
      m = m << (-SCALE_SH);
    end
    if (ph[PB-1]) begin
      if (m > 32768) m = 32768;
      return SINE_W'(-m);
    end
    if (m > 32767) m = 32767;
    return SINE_W'(m);
  endfunction

  function automatic logic [LED_W-1:0] brightness_for(input logic [LED_W-1:0] lmin,
                                                      input logic [LED_W-1:0] lmax);
    int off;
    int amp;
    longint t;
    longint r;
    off = (int'(lmax) + int'(lmin)) / 2;
    amp = int'(lmax) - off;
    t = longint'(sine_acc) * amp + longint'(off) * 32768;
    if (t < 0) return '0;
    r = t / 32768;
    if (r > 255) r = 255;
    return LED_W'(r);
  endfunction

  // Updates the local phase and sine state and returns the result of one transfer.
  function automatic led_result_t apply_item(input kind_t k, input logic [LED_W-1:0] lmin,
                                             input logic [LED_W-1:0] lmax);
    led_result_t res;
    res.brightness = '0;
    case (k)
      KIND_TICK: begin
        phase_acc = phase_acc + step_reg[PB-1:0];
        sine_acc = sine_at(phase_acc);
      end
      KIND_PEAK: begin
        phase_acc = PB'(1) << (PB - 2);
      end
      KIND_TROUGH: begin
        phase_acc = -(PB'(1) << (PB - 2));
      end
      default: begin
        res.brightness = brightness_for(lmin, lmax);
      end
    endcase
    res.sine_value = sine_acc;
    return res;
  endfunction

  task automatic send_item(input kind_t k, input logic [LED_W-1:0] lmin,
                           input logic [LED_W-1:0] lmax);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      s_tdata <= (2 * LED_W)'($urandom);
      s_tuser <= KIND_W'($urandom);
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {lmax, lmin};
    s_tuser <= k;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(apply_item(k, lmin, lmax));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_phase_step(input logic [STEP_W-1:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    step_reg = value;
  endtask

  task automatic send_random_items(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 50) begin
        send_item(KIND_TICK, LED_W'($urandom), LED_W'($urandom));
      end else if (pick < 85) begin
        send_item(KIND_BRIGHT, LED_W'($urandom), LED_W'($urandom));
      end else if (pick < 93) begin
        send_item(KIND_PEAK, LED_W'($urandom), LED_W'($urandom));
      end else begin
        send_item(KIND_TROUGH, LED_W'($urandom), LED_W'($urandom));
      end
    end
  endtask

  // With the reset step of zero a tick leaves the phase at zero and the sine at zero.
  task automatic test_reset_state();
    send_item(KIND_TICK, 8'd0, 8'd0);
    send_item(KIND_BRIGHT, 8'd0, 8'd255);
    send_item(KIND_BRIGHT, 8'd255, 8'd0);
  endtask

  task automatic test_peak_trough_extremes();
    send_item(KIND_PEAK, 8'd255, 8'd255);
    send_item(KIND_BRIGHT, 8'd0, 8'd255);
    send_item(KIND_TICK, 8'd0, 8'd0);
    send_item(KIND_BRIGHT, 8'd0, 8'd255);
    send_item(KIND_BRIGHT, 8'd255, 8'd0);
    send_item(KIND_BRIGHT, 8'd255, 8'd255);
    send_item(KIND_BRIGHT, 8'd0, 8'd0);
    send_item(KIND_TROUGH, 8'd0, 8'd0);
    send_item(KIND_TICK, 8'd255, 8'd255);
    send_item(KIND_BRIGHT, 8'd0, 8'd255);
    send_item(KIND_BRIGHT, 8'd255, 8'd0);
  endtask

  // A quarter-turn step walks through zero, the peak, the half-turn wrap and the trough.
  task automatic test_quarter_steps();
    set_phase_step(16'h4000);
    send_item(KIND_TICK, 8'd0, 8'd0);
    send_item(KIND_TICK, 8'd0, 8'd0);
    send_item(KIND_TICK, 8'd0, 8'd0);
    send_item(KIND_BRIGHT, 8'd200, 8'd100);
    send_item(KIND_TICK, 8'd0, 8'd0);
    set_phase_step(16'hFFFF);
    send_item(KIND_TICK, 8'd0, 8'd0);
    send_item(KIND_TICK, 8'd0, 8'd0);
    send_item(KIND_BRIGHT, 8'd17, 8'd240);
  endtask

  task automatic test_random_steps();
    logic [STEP_W-1:0] steps[5];
    steps[0] = STEP_W'($urandom_range(1, 1024));
    steps[1] = 16'h0001;
    steps[2] = STEP_W'($urandom);
    steps[3] = 16'h8000;
    steps[4] = 16'h0000;
    foreach (steps[i]) begin
      set_phase_step(steps[i]);
      send_random_items(ITEMS_PER_PHASE);
    end
  endtask

  task automatic test_full_rate();
    set_phase_step(STEP_W'($urandom));
    idle_on = 1'b0;
    send_random_items(ITEMS_PER_PHASE);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    phase_acc = '0;
    sine_acc = '0;
    step_reg = '0;
    mismatch_cnt = 0;
    idle_on = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_peak_trough_extremes();
    test_quarter_steps();
    test_random_steps();
    test_full_rate();
    drain_results();
    if (mismatch_cnt == 0) begin
      $display("[led_breathing_sine_generator_top] OK");
    end else begin
      $display("[led_breathing_sine_generator_top] ERROR");
    end
    $finish;
  end

  initial begin
    m_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    led_result_t want;
    led_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.brightness = m_tdata[LED_W-1:0];
      got.sine_value = m_tdata[LED_W+SINE_W-1:LED_W];
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("unexpected result transfer: brightness %0d sine %0d",
                   got.brightness, got.sine_value);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.brightness !== want.brightness || got.sine_value !== want.sine_value) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("result mismatch: brightness exp %0d got %0d, sine exp %0d got %0d",
                     want.brightness, got.brightness, want.sine_value, got.sine_value);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("[led_breathing_sine_generator_top] ERROR");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

endmodule

>>> led_breathing_sine_generator_top.f
+incdir+rtl/core
rtl/core/lbsg_pkg.sv
rtl/core/lbsg_mul.sv
rtl/core/led_breathing_sine_generator_top.sv
sim/tb_top.sv
